### rtl/core/triangle_flat_normal_emitter_defines.svh
// Assertion macros used by the checker file of the normal emitter.
`ifndef TRIANGLE_FLAT_NORMAL_EMITTER_DEFINES_SVH
`define TRIANGLE_FLAT_NORMAL_EMITTER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TFNE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define TFNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tfne_pkg.sv
// Package with widths, constants and shared types of the normal emitter.
package tfne_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FIELD_W = 32;
   localparam int NORM_W = 16;
   localparam int EDGE_W = 33;
   localparam int CROSS_W = 66;
   localparam int MAG_W = 64;
   localparam int SQ_W = 64;
   localparam int ROOT_W = 32;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_W = 46;
   localparam int DIV_STEPS = 15;
   localparam int Q14_ONE = 16384;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;
   localparam logic [31:0] MIN_LEN_RESET = 32'd4295;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic signed [NORM_W-1:0] norm_type;

   // One triangle's corners, as taken from the request port.
   typedef struct packed {
      field_type a_x, a_y, a_z;
      field_type b_x, b_y, b_z;
      field_type c_x, c_y, c_z;
   } tri_type;

   // One finished triangle: corners plus shared normal.
   typedef struct packed {
      field_type a_x, a_y, a_z;
      field_type b_x, b_y, b_z;
      field_type c_x, c_y, c_z;
      norm_type  n_x, n_y, n_z;
   } done_type;

   // Queue entry: corners, signs, scaled magnitudes, shifts, zero flag.
   localparam int QUEUE_W = $bits(tri_type) + 3 + 3 * 32 + 2 + 5 + 1;

   // Sign extend the low COORD_WIDTH bits of a field.
   function automatic field_type coord_in(input field_type raw);
      logic [COORD_WIDTH-1:0] v;
      begin
         v = raw[COORD_WIDTH-1:0];
         return FIELD_W'(signed'(v));
      end
   endfunction

endpackage

### rtl/core/tfne_front.sv
// Front end: edge vectors, cross product and magnitude scaling.
module tfne_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  tfne_pkg::tri_type in_tri,
   output logic out_valid,
   input  logic out_stall,
   output tfne_pkg::tri_type out_tri,
   output logic [2:0] out_neg,
   output logic [2:0][31:0] out_sm,
   output logic [1:0] out_rshift,
   output logic [4:0] out_lshift,
   output logic out_zero
);
   import tfne_pkg::*;

   // Pipeline: s1 edges, s2 products, s3 cross, s4 scale.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv;
   assign adv = !(v4_ff && out_stall);
   assign in_stall = !adv;

   tri_type t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [EDGE_W-1:0] u_ff [3];
   logic signed [EDGE_W-1:0] w_ff [3];
   logic signed [EDGE_W-1:0] u_in [3];
   logic signed [EDGE_W-1:0] w_in [3];
   logic signed [CROSS_W-1:0] pr_ff [6];
   logic signed [CROSS_W-1:0] n_ff [3];
   logic [2:0] neg_ff;
   logic [2:0][31:0] sm_ff;
   logic [1:0] rs_ff;
   logic [4:0] ls_ff;
   logic zero_ff;
   tri_type tc;

   function automatic logic signed [EDGE_W-1:0] edge_sat(input field_type to,
                                                         input field_type from);
      logic signed [EDGE_W-1:0] d;
      begin
         d = EDGE_W'(to) - EDGE_W'(from);
         if (d > $signed({2'b00, {31{1'b1}}})) d = $signed({2'b00, {31{1'b1}}});
         if (d < -$signed({2'b00, {31{1'b1}}})) d = -$signed({2'b00, {31{1'b1}}});
         return d;
      end
   endfunction

   always_comb begin
      tc.a_x = coord_in(in_tri.a_x);
      tc.a_y = coord_in(in_tri.a_y);
      tc.a_z = coord_in(in_tri.a_z);
      tc.b_x = coord_in(in_tri.b_x);
      tc.b_y = coord_in(in_tri.b_y);
      tc.b_z = coord_in(in_tri.b_z);
      tc.c_x = coord_in(in_tri.c_x);
      tc.c_y = coord_in(in_tri.c_y);
      tc.c_z = coord_in(in_tri.c_z);
      u_in[0] = edge_sat(tc.b_x, tc.a_x);
      u_in[1] = edge_sat(tc.b_y, tc.a_y);
      u_in[2] = edge_sat(tc.b_z, tc.a_z);
      w_in[0] = edge_sat(tc.c_x, tc.a_x);
      w_in[1] = edge_sat(tc.c_y, tc.a_y);
      w_in[2] = edge_sat(tc.c_z, tc.a_z);
   end

   // Normalizing shift: exact right shift for large, left shift for small.
   logic [MAG_W-1:0] mg [3];
   logic [MAG_W-1:0] mx;
   logic big_c;
   logic [4:0] ls_c;
   logic [5:0] rr_c;
   logic [2:0][31:0] sm2_c;
   always_comb begin
      for (int i = 0; i < 3; i++)
         mg[i] = n_ff[i][CROSS_W-1] ? MAG_W'(-n_ff[i]) : MAG_W'(n_ff[i]);
      mx = mg[0];
      if (mg[1] > mx) mx = mg[1];
      if (mg[2] > mx) mx = mg[2];
      big_c = (mx >= (64'd1 << 31));
      // small: lift the top set bit to bit 30
      ls_c = 5'd0;
      for (int b = 0; b < 31; b++)
         if (mx[b]) ls_c = 5'(30 - b);
      // large: drop until the top set bit sits at bit 30
      rr_c = 6'd0;
      for (int b = 0; b < 32; b++)
         if (mx[b + 31]) rr_c = 6'(b + 1);
      for (int i = 0; i < 3; i++)
         sm2_c[i] = big_c ? 32'(mg[i] >> rr_c) : 32'(mg[i] << ls_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= tc;
         u_ff <= u_in;
         w_ff <= w_in;
         t2_ff <= t1_ff;
         pr_ff[0] <= CROSS_W'(u_ff[1]) * CROSS_W'(w_ff[2]);
         pr_ff[1] <= CROSS_W'(u_ff[2]) * CROSS_W'(w_ff[1]);
         pr_ff[2] <= CROSS_W'(u_ff[2]) * CROSS_W'(w_ff[0]);
         pr_ff[3] <= CROSS_W'(u_ff[0]) * CROSS_W'(w_ff[2]);
         pr_ff[4] <= CROSS_W'(u_ff[0]) * CROSS_W'(w_ff[1]);
         pr_ff[5] <= CROSS_W'(u_ff[1]) * CROSS_W'(w_ff[0]);
         t3_ff <= t2_ff;
         n_ff[0] <= pr_ff[0] - pr_ff[1];
         n_ff[1] <= pr_ff[2] - pr_ff[3];
         n_ff[2] <= pr_ff[4] - pr_ff[5];
         t4_ff <= t3_ff;
         for (int i = 0; i < 3; i++) neg_ff[i] <= n_ff[i][CROSS_W-1];
         sm_ff <= sm2_c;
         rs_ff <= (rr_c > 6'd2) ? 2'd2 : rr_c[1:0];
         ls_ff <= big_c ? 5'd0 : ls_c;
         zero_ff <= (mx == '0);
      end
   end

   assign out_valid = v4_ff;
   assign out_tri = t4_ff;
   assign out_neg = neg_ff;
   assign out_sm = sm_ff;
   assign out_rshift = rs_ff;
   assign out_lshift = ls_ff;
   assign out_zero = zero_ff;
endmodule

### rtl/core/tfne_queue.sv
// Short queue between the front and back ends.
module tfne_queue (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   output logic wr_stall,
   input  logic [tfne_pkg::QUEUE_W-1:0] wr_data,
   output logic rd_valid,
   input  logic rd_take,
   output logic [tfne_pkg::QUEUE_W-1:0] rd_data
);
   import tfne_pkg::*;

   logic [QUEUE_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, rp_ff;
   logic [QUEUE_AW:0] cnt_ff;
   logic wr, rd;

   assign wr_stall = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign wr = wr_valid && !wr_stall;
   assign rd = rd_take && rd_valid;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_AW+1)'(wr) - (QUEUE_AW+1)'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

### rtl/core/tfne_back.sv
// Back end: square root, threshold test, division and vertex emission.
module tfne_back (
   input  logic clock,
   input  logic reset,
   input  logic [31:0] min_len,
   input  logic in_valid,
   output logic in_take,
   input  tfne_pkg::tri_type in_tri,
   input  logic [2:0] in_neg,
   input  logic [2:0][31:0] in_sm,
   input  logic [1:0] in_rshift,
   input  logic [4:0] in_lshift,
   input  logic in_zero,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tfne_pkg::done_type rsp_done,
   output logic [1:0] rsp_idx
);
   import tfne_pkg::*;

   // Sequencer: load, root, divide, then emit three vertices.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ROOT = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } st_type;

   st_type st_ff, st_in;
   logic [5:0] cnt_ff;
   logic [SQ_W-1:0] rem_ff;
   logic [SQ_W-1:0] s_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [2:0][31:0] sm_ff;
   logic [2:0] neg_ff;
   tri_type tri_ff;
   logic [1:0] rs_ff;
   logic zero_ff;
   logic [1:0] idx_ff;
   logic [2:0][DIV_STEPS-1:0] low_ff;
   logic [2:0][DIV_STEPS-1:0] quo_ff;
   logic [2:0][ROOT_W-1:0] drem_ff;
   norm_type nx_ff, ny_ff, nz_ff;

   // Root of the coarse sum decides validity; root of the normalized sum divides.
   logic [SQ_W-1:0] sq_raw;
   logic [ROOT_W-1:0] root_raw_ff;
   logic [SQ_W-1:0] rem2_ff;
   logic [SQ_W-1:0] s2_ff;

   logic emit_done;
   assign emit_done = (st_ff == ST_EMIT) && !rsp_stall && idx_ff == 2'd2;
   assign in_take = (st_ff == ST_IDLE) && in_valid;

   // One restoring square root step on both sums together.
   logic [SQ_W-1:0] trial, trial2;
   logic [1:0] pair, pair2;
   always_comb begin
      pair = 2'(s_ff >> (2 * (31 - cnt_ff[4:0])));
      pair2 = 2'(s2_ff >> (2 * (31 - cnt_ff[4:0])));
      trial = {rem_ff[SQ_W-3:0], pair} - {30'd0, root_raw_ff, 2'b01};
      trial2 = {rem2_ff[SQ_W-3:0], pair2} - {30'd0, root_ff, 2'b01};
   end

   // Normalized sum of squares; the coarse sum is it shifted back down.
   logic [SQ_W-1:0] sum_raw;
   always_comb begin
      sq_raw = '0;
      sum_raw = '0;
      for (int i = 0; i < 3; i++) begin
         sq_raw = sq_raw + 64'(in_sm[i]) * 64'(in_sm[i]);
      end
      sum_raw = sq_raw;
   end

   // One long division step per lane: remainder and next quotient bit.
   logic [2:0][DIV_W-1:0] num_c;
   logic [2:0][ROOT_W:0] part_c;
   logic [2:0] ge_c;
   logic [2:0][ROOT_W-1:0] drem_c;
   logic [2:0][DIV_STEPS-1:0] quo_c;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_c[i] = (DIV_W'(sm_ff[i]) << 14) + DIV_W'(root_ff >> 1);
         part_c[i] = {drem_ff[i], low_ff[i][DIV_STEPS-1]};
         ge_c[i] = (part_c[i] >= {1'b0, root_ff});
         drem_c[i] = ge_c[i] ? ROOT_W'(part_c[i] - {1'b0, root_ff})
                             : part_c[i][ROOT_W-1:0];
         quo_c[i] = {quo_ff[i][DIV_STEPS-2:0], ge_c[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (in_valid) st_in = ST_ROOT;
         ST_ROOT: if (cnt_ff == 6'(SQRT_STEPS - 1)) st_in = ST_DIV;
         ST_DIV:  if (cnt_ff == 6'(DIV_STEPS)) st_in = ST_EMIT;
         ST_EMIT: if (emit_done) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   logic valid_c;
   always_comb begin
      valid_c = !zero_ff && ((rs_ff >= 2'd2) || (({32'd0, root_raw_ff} << rs_ff) >
                64'(min_len)));
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            tri_ff <= in_tri;
            neg_ff <= in_neg;
            sm_ff <= in_sm;
            rs_ff <= in_rshift;
            zero_ff <= in_zero;
            s_ff <= sum_raw >> {in_lshift, 1'b0};
            s2_ff <= sum_raw;
            rem_ff <= '0;
            rem2_ff <= '0;
            root_ff <= '0;
            root_raw_ff <= '0;
            cnt_ff <= '0;
            idx_ff <= '0;
         end
         ST_ROOT: begin
            if (!trial[SQ_W-1]) begin
               rem_ff <= trial;
               root_raw_ff <= {root_raw_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[SQ_W-3:0], pair};
               root_raw_ff <= {root_raw_ff[ROOT_W-2:0], 1'b0};
            end
            if (!trial2[SQ_W-1]) begin
               rem2_ff <= trial2;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem2_ff <= {rem2_ff[SQ_W-3:0], pair2};
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= (cnt_ff == 6'(SQRT_STEPS - 1)) ? 6'd0 : cnt_ff + 1'b1;
         end
         ST_DIV: begin
            // First cycle loads the numerator, then one quotient bit per cycle.
            // The quotient never exceeds 16384, so the top bits start below the root.
            for (int i = 0; i < 3; i++) begin
               if (cnt_ff == 6'd0) begin
                  drem_ff[i] <= {1'b0, num_c[i][DIV_W-1:DIV_STEPS]};
                  low_ff[i] <= num_c[i][DIV_STEPS-1:0];
                  quo_ff[i] <= '0;
               end else begin
                  drem_ff[i] <= drem_c[i];
                  low_ff[i] <= {low_ff[i][DIV_STEPS-2:0], 1'b0};
                  quo_ff[i] <= quo_c[i];
               end
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_EMIT: begin
            if (!rsp_stall) idx_ff <= idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   function automatic logic [DIV_STEPS-1:0] clamp(input logic [DIV_STEPS-1:0] v);
      return (v > DIV_STEPS'(Q14_ONE)) ? DIV_STEPS'(Q14_ONE) : v;
   endfunction

   // Final normal, clamped and signed, taken with the last quotient bit; (0, 16384, 0) if the threshold test fails.
   always_ff @(posedge clock) begin
      if (st_ff == ST_DIV && cnt_ff == 6'(DIV_STEPS)) begin
         if (valid_c) begin
            nx_ff <= norm_type'(neg_ff[0] ? -$signed({1'b0, clamp(quo_c[0])})
                                          : $signed({1'b0, clamp(quo_c[0])}));
            ny_ff <= norm_type'(neg_ff[1] ? -$signed({1'b0, clamp(quo_c[1])})
                                          : $signed({1'b0, clamp(quo_c[1])}));
            nz_ff <= norm_type'(neg_ff[2] ? -$signed({1'b0, clamp(quo_c[2])})
                                          : $signed({1'b0, clamp(quo_c[2])}));
         end else begin
            nx_ff <= '0;
            ny_ff <= norm_type'(Q14_ONE);
            nz_ff <= '0;
         end
      end
   end

   assign rsp_valid = (st_ff == ST_EMIT);
   assign rsp_idx = idx_ff;
   always_comb begin
      rsp_done.a_x = tri_ff.a_x;
      rsp_done.a_y = tri_ff.a_y;
      rsp_done.a_z = tri_ff.a_z;
      rsp_done.b_x = tri_ff.b_x;
      rsp_done.b_y = tri_ff.b_y;
      rsp_done.b_z = tri_ff.b_z;
      rsp_done.c_x = tri_ff.c_x;
      rsp_done.c_y = tri_ff.c_y;
      rsp_done.c_z = tri_ff.c_z;
      rsp_done.n_x = nx_ff;
      rsp_done.n_y = ny_ff;
      rsp_done.n_z = nz_ff;
   end

   logic unused;
   assign unused = ^{rem_ff[SQ_W-1:SQ_W-2], rem2_ff[SQ_W-1:SQ_W-2],
                     quo_ff[0][DIV_STEPS-1], quo_ff[1][DIV_STEPS-1], quo_ff[2][DIV_STEPS-1]};
endmodule

### rtl/core/triangle_flat_normal_emitter.sv
// Top level: triangle corners in, three vertices with a flat normal out.
// The back end takes one triangle at a time: load, 32 root steps, division, 3 vertices.
// Meanwhile up to eight more triangles wait in the front pipeline and queue.
// Reset (synchronous, active high) empties the pipeline and queue and loads
// the threshold register min_len_ff with 4295.
module triangle_flat_normal_emitter (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_a_x, req_a_y, req_a_z,
   input  logic signed [31:0] req_b_x, req_b_y, req_b_z,
   input  logic signed [31:0] req_c_x, req_c_y, req_c_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_vertex_x, rsp_vertex_y, rsp_vertex_z,
   output logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z,
   output logic rsp_last_vertex
);
   import tfne_pkg::*;

   logic [31:0] min_len_ff;
   always_ff @(posedge clock) begin
      if (reset) min_len_ff <= MIN_LEN_RESET;
      else if (csr_write_enable) min_len_ff <= csr_write_data;
   end

   tri_type in_tri, f_tri, q_tri;
   assign in_tri = '{req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
                     req_c_x, req_c_y, req_c_z};

   logic f_valid, f_stall, q_valid, q_take, f_zero, q_zero;
   logic [2:0] f_neg, q_neg;
   logic [2:0][31:0] f_sm, q_sm;
   logic [1:0] f_rs, q_rs, idx;
   logic [4:0] f_ls, q_ls;
   done_type done;

   tfne_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_tri,
      .out_valid(f_valid), .out_stall(f_stall), .out_tri(f_tri), .out_neg(f_neg),
      .out_sm(f_sm), .out_rshift(f_rs), .out_lshift(f_ls), .out_zero(f_zero)
   );

   tfne_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_stall(f_stall),
      .wr_data({f_tri, f_neg, f_sm, f_rs, f_ls, f_zero}),
      .rd_valid(q_valid), .rd_take(q_take),
      .rd_data({q_tri, q_neg, q_sm, q_rs, q_ls, q_zero})
   );

   tfne_back u_back (
      .clock, .reset, .min_len(min_len_ff), .in_valid(q_valid), .in_take(q_take),
      .in_tri(q_tri), .in_neg(q_neg), .in_sm(q_sm), .in_rshift(q_rs),
      .in_lshift(q_ls), .in_zero(q_zero), .rsp_valid, .rsp_stall,
      .rsp_done(done), .rsp_idx(idx)
   );

   always_comb begin
      case (idx)
         2'd0: begin
            rsp_vertex_x = done.a_x; rsp_vertex_y = done.a_y; rsp_vertex_z = done.a_z;
         end
         2'd1: begin
            rsp_vertex_x = done.b_x; rsp_vertex_y = done.b_y; rsp_vertex_z = done.b_z;
         end
         default: begin
            rsp_vertex_x = done.c_x; rsp_vertex_y = done.c_y; rsp_vertex_z = done.c_z;
         end
      endcase
   end
   assign rsp_normal_x = done.n_x;
   assign rsp_normal_y = done.n_y;
   assign rsp_normal_z = done.n_z;
   assign rsp_last_vertex = (idx == 2'd2);
endmodule

### rtl/core/tfne_checker.sv
// Port-level checker for the normal emitter, bound to the top level.
`include "triangle_flat_normal_emitter_defines.svh"
module tfne_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_last_vertex,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic signed [15:0] rsp_normal_z
);
   `TFNE_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "valid dropped")
   `TFNE_ASSERT_IMPL(a_nx, clock, reset, rsp_valid, rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384, "nx range")
   `TFNE_ASSERT_IMPL(a_ny, clock, reset, rsp_valid, rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384, "ny range")
   `TFNE_ASSERT_NEXT(a_last, clock, reset, rsp_valid && !rsp_stall && rsp_last_vertex, !rsp_valid || !rsp_last_vertex, "last twice")
endmodule

bind triangle_flat_normal_emitter tfne_checker u_tfne_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_last_vertex,
   .rsp_normal_x, .rsp_normal_y, .rsp_normal_z
);

### test/tb_top.sv
// Testbench for the triangle flat-normal emitter: scoreboard class plus driver tasks.
`timescale 1ns / 100ps

module tb_top;
   import tfne_pkg::*;

   // One emitted vertex with the shared normal.
   typedef struct {
      field_type vx, vy, vz;
      norm_type  nx, ny, nz;
      logic      last;
   } vertex_type;

   // Keeps its own copy of the threshold and the vertices still due.
   class normal_scoreboard;
      logic [31:0] min_len;
      vertex_type  due[$];
      int          errors;
      int          triangles;
      int          vertices;
      int          upward;

      function new();
         min_len = MIN_LEN_RESET;
      endfunction

      // Integer square root, bit by bit.
      function longint unsigned int_root(longint unsigned s);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > s) bitv >>= 2;
         while (bitv != 0) begin
            if (s >= root + bitv) begin
               s -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function longint take_coord(field_type raw);
         logic signed [COORD_WIDTH-1:0] v;
         v = raw[COORD_WIDTH-1:0];
         return longint'(v);
      endfunction

      function longint edge_sat(longint dst, longint src);
         longint d;
         d = dst - src;
         if (d > 64'sd2147483647) d = 64'sd2147483647;
         if (d < -64'sd2147483647) d = -64'sd2147483647;
         return d;
      endfunction

      // Work out the three vertices of one accepted triangle.
      function void note_triangle(tri_type t);
         longint p[9];
         longint n[3];
         longint unsigned mg[3], sm[3];
         longint unsigned m, s1, s2, len, v;
         longint u0, u1, u2, w0, w1, w2;
         int r, l, i, k;
         bit ok;
         norm_type q[3];
         vertex_type vt;
         p[0] = take_coord(t.a_x); p[1] = take_coord(t.a_y); p[2] = take_coord(t.a_z);
         p[3] = take_coord(t.b_x); p[4] = take_coord(t.b_y); p[5] = take_coord(t.b_z);
         p[6] = take_coord(t.c_x); p[7] = take_coord(t.c_y); p[8] = take_coord(t.c_z);
         u0 = edge_sat(p[3], p[0]); u1 = edge_sat(p[4], p[1]); u2 = edge_sat(p[5], p[2]);
         w0 = edge_sat(p[6], p[0]); w1 = edge_sat(p[7], p[1]); w2 = edge_sat(p[8], p[2]);
         n[0] = u1 * w2 - u2 * w1;
         n[1] = u2 * w0 - u0 * w2;
         n[2] = u0 * w1 - u1 * w0;
         m = 0;
         for (i = 0; i < 3; i++) begin
            mg[i] = n[i] < 0 ? longint'(-n[i]) : n[i];
            if (mg[i] > m) m = mg[i];
         end
         // threshold test on the coarsely scaled length
         ok = 0;
         if (m != 0) begin
            r = 0;
            while ((m >> r) >= (64'd1 << 31)) r++;
            s1 = 0;
            for (i = 0; i < 3; i++) s1 += (mg[i] >> r) * (mg[i] >> r);
            ok = (r >= 2) || ((int_root(s1) << r) > {32'd0, min_len});
         end
         if (ok) begin
            // bring the largest component into [2^30, 2^31)
            if (m >= (64'd1 << 31)) begin
               r = 0;
               while ((m >> r) >= (64'd1 << 31)) r++;
               for (i = 0; i < 3; i++) sm[i] = mg[i] >> r;
            end else begin
               l = 0;
               while ((m << l) < (64'd1 << 30)) l++;
               for (i = 0; i < 3; i++) sm[i] = mg[i] << l;
            end
            s2 = 0;
            for (i = 0; i < 3; i++) s2 += sm[i] * sm[i];
            len = int_root(s2);
            for (i = 0; i < 3; i++) begin
               v = (sm[i] * Q14_ONE + (len >> 1)) / len;
               if (v > Q14_ONE) v = Q14_ONE;
               q[i] = n[i] < 0 ? -norm_type'(v) : norm_type'(v);
            end
         end else begin
            q[0] = 0; q[1] = norm_type'(Q14_ONE); q[2] = 0;
            upward++;
         end
         for (k = 0; k < 3; k++) begin
            vt.vx = field_type'(p[3*k]);
            vt.vy = field_type'(p[3*k+1]);
            vt.vz = field_type'(p[3*k+2]);
            vt.nx = q[0]; vt.ny = q[1]; vt.nz = q[2];
            vt.last = (k == 2);
            due.push_back(vt);
         end
         triangles++;
      endfunction

      // Compare one emitted vertex with the oldest one due.
      function void check_vertex(vertex_type got);
         vertex_type exp_v;
         vertices++;
         if (due.size() == 0) begin
            $display("%0t: vertex with nothing due: %h %h %h", $time, got.vx, got.vy, got.vz);
            errors++;
            return;
         end
         exp_v = due.pop_front();
         if (got.vx !== exp_v.vx || got.vy !== exp_v.vy || got.vz !== exp_v.vz) begin
            $display("%0t: position exp %h %h %h got %h %h %h", $time,
                     exp_v.vx, exp_v.vy, exp_v.vz, got.vx, got.vy, got.vz);
            errors++;
         end
         if (got.nx !== exp_v.nx || got.ny !== exp_v.ny || got.nz !== exp_v.nz) begin
            $display("%0t: normal exp %0d %0d %0d got %0d %0d %0d", $time,
                     exp_v.nx, exp_v.ny, exp_v.nz, got.nx, got.ny, got.nz);
            errors++;
         end
         if (got.last !== exp_v.last) begin
            $display("%0t: last flag exp %b got %b", $time, exp_v.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [31:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   field_type req_a_x = 0, req_a_y = 0, req_a_z = 0;
   field_type req_b_x = 0, req_b_y = 0, req_b_z = 0;
   field_type req_c_x = 0, req_c_y = 0, req_c_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   field_type rsp_vertex_x, rsp_vertex_y, rsp_vertex_z;
   norm_type rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_last_vertex;

   normal_scoreboard sb = new();
   bit quiet = 0;
   bit hold_rsp = 0;
   int stall_left = 0;
   int cycles = 0;

   triangle_flat_normal_emitter u_top (.*);

   always #4 clock = ~clock;

   // Acceptance on both channels, sampled at the edge.
   always @(posedge clock) begin
      tri_type t;
      vertex_type got;
      if (!reset && req_valid && !req_stall) begin
         t = '{req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
               req_c_x, req_c_y, req_c_z};
         sb.note_triangle(t);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_vertex_x, rsp_vertex_y, rsp_vertex_z,
                 rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_last_vertex};
         sb.check_vertex(got);
      end
   end

   // Receiver stalls in bursts; a long hold overrides them.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_rsp) begin
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("triangle_flat_normal_emitter: mismatch");
         $finish;
      end
   end

   // Offer one triangle and hold it until taken, then maybe leave a gap.
   task automatic send_triangle(tri_type t);
      req_valid <= 1;
      {req_a_x, req_a_y, req_a_z} <= {t.a_x, t.a_y, t.a_z};
      {req_b_x, req_b_y, req_b_z} <= {t.b_x, t.b_y, t.b_z};
      {req_c_x, req_c_y, req_c_z} <= {t.c_x, t.c_y, t.c_z};
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_min_len(logic [31:0] val);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.min_len = val;
   endtask

   function automatic field_type small_off();
      int w;
      w = 1 << $urandom_range(0, 20);
      return field_type'($urandom_range(0, 2 * w)) - field_type'(w);
   endfunction

   function automatic field_type pick_extreme();
      case ($urandom_range(0, 4))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // Random triangle: mostly small well-formed ones near a random base.
   function automatic tri_type rand_triangle();
      tri_type t;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
         t = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else if (mode < 4) begin
         t = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
              pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
              pick_extreme()};
      end else begin
         t.a_x = $urandom; t.a_y = $urandom; t.a_z = $urandom;
         if (mode < 6) begin
            t.a_x >>>= 8; t.a_y >>>= 8; t.a_z >>>= 8;
         end
         t.b_x = t.a_x + small_off(); t.b_y = t.a_y + small_off();
         t.b_z = t.a_z + small_off();
         t.c_x = t.a_x + small_off(); t.c_y = t.a_y + small_off();
         t.c_z = t.a_z + small_off();
      end
      return t;
   endfunction

   task automatic random_triangles(int count);
      repeat (count) send_triangle(rand_triangle());
   endtask

   initial begin
      logic [31:0] setting;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: degenerate, axis-aligned, threshold edge, saturation, extremes.
      send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_triangle('{5, 5, 5, 5, 5, 5, 5, 5, 5});
      send_triangle('{0, 0, 0, 1, 2, 3, 2, 4, 6});
      send_triangle('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0});
      send_triangle('{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0});
      send_triangle('{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
      send_triangle('{0, 0, 0, 65, 0, 0, 0, 66, 0});
      send_triangle('{0, 0, 0, 66, 0, 0, 0, 66, 0});
      send_triangle('{0, 0, 0, 4295, 0, 0, 0, 1, 0});
      send_triangle('{0, 0, 0, 4296, 0, 0, 0, -1, 0});
      send_triangle('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
      send_triangle('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                      32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                      32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF});
      send_triangle('{32'sh80000000, 32'sh7FFFFFFF, 0,
                      32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                      0, 32'sh80000000, 32'sh80000000});
      send_triangle('{-1, -1, -1, 0, -1, 3, 7, -2, -1});
      send_triangle('{1, 2, 3, 1, 2, 3, 100000, 200000, 300000});
      random_triangles(60);

      // Threshold zero, with a long receiver hold so the input backs up.
      write_min_len(32'd0);
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
      join_none
      random_triangles(80);

      // Largest threshold, with a pause until everything has come out.
      write_min_len(32'hFFFFFFFF);
      random_triangles(40);
      drain();
      random_triangles(40);

      // Random threshold, then back to the reset value, the last run without gaps or stalls.
      setting = $urandom_range(1, 200000);
      write_min_len(setting);
      random_triangles(90);
      write_min_len(MIN_LEN_RESET);
      quiet = 1;
      random_triangles(90);

      req_valid <= 0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("Covered %0d triangles, %0d vertices, %0d with the upward default normal,",
               sb.triangles, sb.vertices, sb.upward);
      $display("over five thresholds with random stalls, a long hold and a drained pause.");
      if (sb.errors == 0 && sb.due.size() == 0) begin
         $display("triangle_flat_normal_emitter: match");
      end else begin
         $display("triangle_flat_normal_emitter: mismatch");
      end
      $finish;
   end

endmodule
